// ===== sv/sorted_unique_set_insert_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted unique set insert unit assertion macros
// Concurrent assertion wrappers on clk with synchronous reset rst.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_SET_INSERT_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_SET_INSERT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SUSI_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sorted set invariant violated");
`define SUSI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted set same-cycle check failed");
`define SUSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted set next-cycle check failed");
`else
`define SUSI_ASSERT_ALWAYS(lbl, cond)
`define SUSI_ASSERT_SAME(lbl, ante, cons)
`define SUSI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/susi_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted unique set insert package
// Field widths, request and status codes, and the cell flag type.
// ----------------------------------------------------------------------------
package susi_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int IN_VALUE_W = 32;
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

// ===== sv/susi_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request transaction.
// ----------------------------------------------------------------------------
interface susi_req_if import susi_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [REQ_TYPE_W-1:0]        req_type;
  logic signed [IN_VALUE_W-1:0] value;
  logic [INDEX_W-1:0]           index;

  modport source (output valid, req_type, value, index, input ready);
  modport sink (input valid, req_type, value, index, output ready);
endinterface

// ===== sv/susi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response transaction.
// ----------------------------------------------------------------------------
interface susi_rsp_if import susi_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [STATUS_W-1:0]          status;
  logic signed [IN_VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]           element_count;

  modport source (output valid, status, read_value, element_count, input ready);
  modport sink (input valid, status, read_value, element_count, output ready);
endinterface

// ===== sv/sorted_unique_set_insert_unit.sv =====
// A request is accepted in S_IDLE and moves the unit to S_EVAL; its response
// is registered and rsp.valid set when S_EVAL commits, which waits while rsp stalls.
// No new request is taken until then, since the whole cell chain compares
// against the key and shifts in the single evaluate step.
// Reset empties the set; stored elements keep their contents and are unused.
// ----------------------------------------------------------------------------
// Sorted unique set insert unit
// Ascending set of distinct signed values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
`include "sorted_unique_set_insert_unit_assert.svh"

module sorted_unique_set_insert_unit import susi_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  susi_req_if.sink   req,
  susi_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic                          state;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  logic [REQ_TYPE_W-1:0]         op;
  logic signed [VALUE_WIDTH-1:0] key;
  logic signed [VALUE_WIDTH-1:0] key_in;
  logic [INDEX_W-1:0]            rd_index;

  cell_flags_t                   flags [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [VALUE_WIDTH-1:0]        tap [CAPACITY];
  logic [CAPACITY-1:0]           lt_vec;
  logic [CAPACITY-1:0]           eq_vec;
  logic [CAPACITY-1:0]           lt_gap;
  logic [VALUE_WIDTH-1:0]        rd_word;
  logic [IN_VALUE_W-1:0]         rd_ext;
  logic [IW-1:0]                 rd_index_ext;

  logic                          commit;
  logic                          is_dup;
  logic                          is_full;
  logic                          in_range;
  logic                          insert_en;
  logic [STATUS_W-1:0]           status_next;
  logic [IN_VALUE_W-1:0]         read_next;
  logic [COUNT_W-1:0]            count_out;

  logic                          out_valid;
  logic [STATUS_W-1:0]           out_status;
  logic [IN_VALUE_W-1:0]         out_read;
  logic [COUNT_W-1:0]            out_count;

  generate
    if (VALUE_WIDTH <= IN_VALUE_W) begin : g_key_narrow
      assign key_in = req.value[VALUE_WIDTH-1:0];
      assign rd_ext = {{(IN_VALUE_W - VALUE_WIDTH + 1){rd_word[VALUE_WIDTH-1]}},
                       rd_word[VALUE_WIDTH-2:0]};
    end else begin : g_key_wide
      assign key_in = {{(VALUE_WIDTH - IN_VALUE_W){req.value[IN_VALUE_W-1]}}, req.value};
      assign rd_ext = rd_word[IN_VALUE_W-1:0];
    end
    if (CW >= COUNT_W) begin : g_cnt_wide
      assign count_out = count_next[COUNT_W-1:0];
    end else begin : g_cnt_narrow
      assign count_out = {{(COUNT_W - CW){1'b0}}, count_next};
    end
  endgenerate

  assign rd_index_ext = {{(IW - INDEX_W){1'b0}}, rd_index};

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                          prev_lt;
      logic signed [VALUE_WIDTH-1:0] prev_value;
      if (i == 0) begin : g_head
        assign prev_lt    = 1'b1;
        assign prev_value = key;
      end else begin : g_link
        assign prev_lt    = flags[i-1].lt;
        assign prev_value = cell_value[i-1];
      end
      susi_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CW          (CW),
        .INDEX       (i)
      ) u_cell (
        .clk        (clk),
        .count      (count),
        .key        (key),
        .prev_lt    (prev_lt),
        .prev_value (prev_value),
        .insert_en  (insert_en),
        .flags      (flags[i]),
        .value      (cell_value[i])
      );
      assign lt_vec[i] = flags[i].lt;
      assign eq_vec[i] = flags[i].eq;
      assign tap[i]    = (rd_index_ext == IW'(i)) ? cell_value[i] : '0;
    end
  endgenerate

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | tap[i];
    end
  end

  assign lt_gap    = lt_vec & ~{lt_vec[CAPACITY-2:0], 1'b1};
  assign commit    = (state == S_EVAL) && (!out_valid || rsp.ready);
  assign is_dup    = |eq_vec;
  assign is_full   = count == CW'(CAPACITY);
  assign in_range  = rd_index_ext < IW'(count);
  assign insert_en = commit && (op == REQ_INSERT) && !is_dup && !is_full;

  always_comb begin
    status_next = ST_DONE;
    read_next   = '0;
    count_next  = count;
    unique case (op)
      REQ_INSERT: begin
        if (is_dup) begin
          status_next = ST_DUP;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      REQ_READ: begin
        if (in_range) begin
          read_next = rd_ext;
        end else begin
          status_next = ST_RANGE;
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op       <= req.req_type;
      key      <= key_in;
      rd_index <= req.index;
    end
    if (commit) begin
      out_status <= status_next;
      out_read   <= read_next;
      out_count  <= count_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (commit) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign req.ready         = state == S_IDLE;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.read_value    = out_read;
  assign rsp.element_count = out_count;

  `SUSI_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY))
  `SUSI_ASSERT_SAME(a_single_match, state == S_EVAL, $onehot0(eq_vec))
  `SUSI_ASSERT_SAME(a_lt_prefix, state == S_EVAL, lt_gap == '0)
  `SUSI_ASSERT_NEXT(a_idle_count_hold, state == S_IDLE, $stable(count))
  `SUSI_ASSERT_NEXT(a_dup_count_hold, commit && op == REQ_INSERT && is_dup, $stable(count))

endmodule

// ===== sv/susi_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one element, compares it with the key and shifts on insert.
// ----------------------------------------------------------------------------
module susi_cell import susi_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = 7,
  parameter int INDEX       = 0
) (
  input  logic                          clk,
  input  logic [CW-1:0]                 count,
  input  logic signed [VALUE_WIDTH-1:0] key,
  input  logic                          prev_lt,
  input  logic signed [VALUE_WIDTH-1:0] prev_value,
  input  logic                          insert_en,
  output cell_flags_t                   flags,
  output logic signed [VALUE_WIDTH-1:0] value
);

  logic occupied;

  assign occupied = count > CW'(INDEX);
  assign flags.lt = occupied && (value < key);
  assign flags.eq = occupied && (value == key);

  always_ff @(posedge clk) begin
    if (insert_en && !flags.lt) begin
      value <= prev_lt ? key : prev_value;
    end
  end

endmodule

// ===== verif/sorted_set_response_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted set response check
// Watches both channels. Each accepted request is applied to a local copy of
// the sorted set, which yields the response owed for it. Each accepted
// response is compared field by field with the oldest response owed.
// ----------------------------------------------------------------------------
module sorted_set_response_check import susi_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  susi_req_if         req,
  susi_rsp_if         rsp,
  output int unsigned owed_count,
  output int unsigned mismatches
);

  typedef struct packed {
    logic [STATUS_W-1:0]          status;
    logic signed [IN_VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]           element_count;
  } set_rsp_t;

  logic signed [VALUE_WIDTH-1:0] set_store [CAPACITY];
  int                            set_count;
  set_rsp_t                      owed_rsp [$];

  function automatic set_rsp_t apply_to_set(input logic [REQ_TYPE_W-1:0] kind,
                                            input logic signed [IN_VALUE_W-1:0] val,
                                            input logic [INDEX_W-1:0] idx);
    set_rsp_t                      r;
    logic signed [VALUE_WIDTH-1:0] key;
    int                            pos;
    r.status        = ST_DONE;
    r.read_value    = '0;
    r.element_count = '0;
    key = VALUE_WIDTH'(val);
    case (kind)
      REQ_INSERT: begin
        pos = 0;
        while (pos < set_count && set_store[pos] < key) pos++;
        if (pos < set_count && set_store[pos] == key) begin
          r.status = ST_DUP;
        end else if (set_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = set_count; k > pos; k--) set_store[k] = set_store[k-1];
          set_store[pos] = key;
          set_count++;
        end
      end
      REQ_READ: begin
        if (int'(idx) < set_count) begin
          r.read_value = IN_VALUE_W'(set_store[idx]);
        end else begin
          r.status = ST_RANGE;
        end
      end
      REQ_CLEAR: begin
        set_count = 0;
      end
      default: begin
      end
    endcase
    r.element_count = COUNT_W'(set_count);
    return r;
  endfunction

  always @(posedge clk) begin
    set_rsp_t want;
    if (rst) begin
      set_count  = 0;
      mismatches = 0;
      owed_rsp.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed_rsp.size() == 0) begin
          $display("%0t unexpected response: status %0d read_value %0d count %0d",
                   $time, rsp.status, rsp.read_value, rsp.element_count);
          mismatches++;
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, rsp.status);
            mismatches++;
          end
          if (rsp.read_value !== want.read_value) begin
            $display("%0t read_value mismatch: expected %0d, actual %0d",
                     $time, want.read_value, rsp.read_value);
            mismatches++;
          end
          if (rsp.element_count !== want.element_count) begin
            $display("%0t element_count mismatch: expected %0d, actual %0d",
                     $time, want.element_count, rsp.element_count);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        owed_rsp.push_back(apply_to_set(req.req_type, req.value, req.index));
      end
    end
    owed_count <= owed_rsp.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted unique set insert unit testbench
// Drives a directed set of requests and then random episodes of inserts,
// reads, clears and unused request codes under four idling and stall phases,
// while a separate check module predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
  import susi_pkg::*;

  localparam int          CAPACITY     = 64;
  localparam int          VALUE_WIDTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 1500;

  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned owed_count;
  int unsigned mismatches;

  susi_req_if req ();
  susi_rsp_if rsp ();

  sorted_unique_set_insert_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  sorted_set_response_check #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) response_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .owed_count (owed_count),
    .mismatches (mismatches)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  task automatic send_item(input logic [REQ_TYPE_W-1:0] kind,
                           input logic signed [IN_VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.req_type <= kind;
    req.value    <= val;
    req.index    <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_VALUE_W-1:0] pick_value(input int unsigned spread);
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $urandom;
      default: return int'($urandom_range(2 * spread)) - int'(spread);
    endcase
  endfunction

  task automatic run_episode(input int unsigned budget, output int unsigned sent);
    int unsigned len;
    int unsigned spread;
    int unsigned roll;
    len    = $urandom_range(30, 200);
    if (len + 1 > budget) len = (budget > 1) ? budget - 1 : 0;
    spread = $urandom_range(1) ? 40 : 300;
    send_item(REQ_CLEAR, $urandom, INDEX_W'($urandom));
    for (int unsigned n = 0; n < len; n++) begin
      roll = $urandom_range(99);
      if (roll < 62) begin
        send_item(REQ_INSERT, pick_value(spread), INDEX_W'($urandom));
      end else if (roll < 97) begin
        send_item(REQ_READ, $urandom, INDEX_W'($urandom));
      end else if (roll < 98) begin
        send_item(REQ_CLEAR, $urandom, INDEX_W'($urandom));
      end else begin
        send_item(REQ_UNUSED, $urandom, INDEX_W'($urandom));
      end
    end
    sent = len + 1;
  endtask

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned phase_items;
    req.valid    = 1'b0;
    req.req_type = REQ_INSERT;
    req.value    = '0;
    req.index    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(REQ_READ, 0, 0);
    send_item(REQ_INSERT, 32'sh7fff_ffff, 0);
    send_item(REQ_INSERT, 32'sh8000_0000, '1);
    send_item(REQ_INSERT, 0, 0);
    send_item(REQ_INSERT, -1, 0);
    send_item(REQ_INSERT, 1, 0);
    send_item(REQ_INSERT, 32'sh7fff_ffff, 0);
    send_item(REQ_INSERT, 32'sh8000_0000, 0);
    send_item(REQ_INSERT, 0, 0);
    for (int i = 0; i < 6; i++) send_item(REQ_READ, '1, INDEX_W'(i));
    send_item(REQ_READ, 0, '1);
    send_item(REQ_UNUSED, 32'sh7fff_ffff, '1);
    send_item(REQ_READ, 0, 4);
    send_item(REQ_CLEAR, -1, '1);
    send_item(REQ_READ, 0, 0);
    send_item(REQ_INSERT, 5, 0);
    send_item(REQ_READ, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 53; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 53; end
        default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
      endcase
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / 4) begin
        run_episode(RANDOM_ITEMS / 4 - phase_items, sent);
        phase_items += sent;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sorted_unique_set_insert_unit.f =====
+incdir+sv
sv/susi_pkg.sv
sv/susi_req_if.sv
sv/susi_rsp_if.sv
sv/susi_cell.sv
sv/sorted_unique_set_insert_unit.sv
verif/sorted_set_response_check.sv
verif/tb.sv
